/* rtl/core/rds_block_sync_and_buffer_core_defines.svh */
// assertion macros for the rds block sync and buffer core
// used by modules that have clk_i and rst_ni in scope
`ifndef RDS_BLOCK_SYNC_AND_BUFFER_CORE_DEFINES_SVH
`define RDS_BLOCK_SYNC_AND_BUFFER_CORE_DEFINES_SVH

// condition holds in the same cycle
`define RDSBSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define RDSBSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rdsbsb_pkg.sv */
// shared types, codes and constants of the rds block sync and buffer core
// no dependencies
package rdsbsb_pkg;

  localparam int DATA_W   = 16;
  localparam int KIND_W   = 3;
  localparam int ERR_W    = 4;
  localparam int CLASS_W  = 2;
  localparam int REQ_W    = 7;
  localparam int SYNC_W   = 2;
  localparam int SUM_W    = 12;
  localparam int CNT_BLK_W = 8;
  localparam int THR_W    = 6;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;
  localparam int REG_IDX_W = 3;

  localparam int RING_BLOCKS_DEF  = 64;
  localparam int GUARD_BLOCKS_DEF = 4;

  // action codes
  localparam logic ACT_WORD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // block kinds
  localparam logic [KIND_W-1:0] KIND_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_E = 3'd5;

  // error classes
  localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_TWO    = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_FIVE   = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_UNCORR = 2'd3;

  // sync status codes
  localparam logic [SYNC_W-1:0] SYNC_INIT = 2'd0;
  localparam logic [SYNC_W-1:0] SYNC_HAVE = 2'd1;
  localparam logic [SYNC_W-1:0] SYNC_FULL = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ERROR_LIMIT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SAVE_E       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNSYNC_BLK   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UNSYNC_BIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNCORR_WGT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FULL_THR     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RX_EN        = 3'd6;

  // register reset values
  localparam logic [ERR_W-1:0]     ERROR_LIMIT_RST  = 4'd5;
  localparam logic [CNT_BLK_W-1:0] UNSYNC_BLK_RST   = 8'd10;
  localparam logic [SUM_W-1:0]     UNSYNC_BIT_RST   = 12'd20;
  localparam logic [ERR_W-1:0]     UNCORR_WGT_RST   = 4'd6;

  localparam logic [ERR_W-1:0] GRADE_TWO_MAX  = 4'd2;
  localparam logic [ERR_W-1:0] GRADE_FIVE_MAX = 4'd5;

  typedef struct packed {
    logic                 action;
    logic [DATA_W-1:0]    word_data;
    logic [KIND_W-1:0]    block_kind;
    logic [ERR_W-1:0]     error_count;
    logic [REQ_W-1:0]     request_blocks;
  } in_item_t;

  typedef struct packed {
    logic                 block_valid;
    logic [DATA_W-1:0]    out_data;
    logic [KIND_W-1:0]    out_block_kind;
    logic [CLASS_W-1:0]   error_class;
    logic                 avail_mark;
    logic                 last;
    logic [REQ_W-1:0]     blocks_read;
    logic [SYNC_W-1:0]    sync_status;
    logic                 data_available;
    logic                 buffer_full;
    logic                 new_data_event;
    logic                 word_stored;
  } out_item_t;

  typedef struct packed {
    logic [ERR_W-1:0]     error_limit;
    logic                 save_e_blocks;
    logic [CNT_BLK_W-1:0] unsync_block_count;
    logic [SUM_W-1:0]     unsync_bit_count;
    logic [ERR_W-1:0]     uncorrectable_weight;
    logic [THR_W-1:0]     full_threshold;
    logic                 receive_enable;
  } cfg_t;

  // one ring entry
  typedef struct packed {
    logic                 avail;
    logic [CLASS_W-1:0]   cls;
    logic [KIND_W-1:0]    kind;
    logic [DATA_W-1:0]    data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // outcome of the sync machine for one word
  typedef struct packed {
    logic                 store;
    logic [CLASS_W-1:0]   cls;
    logic [SYNC_W-1:0]    state_next;
  } sync_dec_t;

endpackage

/* rtl/core/rdsbsb_ram.sv */
// generic single-write, single-read ram with registered read data
// depends on nothing
module rdsbsb_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rdsbsb_regs.sv */
// apb configuration registers of the rds block sync and buffer core
// depends on rdsbsb_pkg
module rdsbsb_regs import rdsbsb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.error_limit          <= ERROR_LIMIT_RST;
      cfg_q.save_e_blocks        <= 1'b0;
      cfg_q.unsync_block_count   <= UNSYNC_BLK_RST;
      cfg_q.unsync_bit_count     <= UNSYNC_BIT_RST;
      cfg_q.uncorrectable_weight <= UNCORR_WGT_RST;
      cfg_q.full_threshold       <= '0;
      cfg_q.receive_enable       <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ERROR_LIMIT: cfg_q.error_limit          <= pwdata[ERR_W-1:0];
        REG_SAVE_E:      cfg_q.save_e_blocks        <= pwdata[0];
        REG_UNSYNC_BLK:  cfg_q.unsync_block_count   <= pwdata[CNT_BLK_W-1:0];
        REG_UNSYNC_BIT:  cfg_q.unsync_bit_count     <= pwdata[SUM_W-1:0];
        REG_UNCORR_WGT:  cfg_q.uncorrectable_weight <= pwdata[ERR_W-1:0];
        REG_FULL_THR:    cfg_q.full_threshold       <= pwdata[THR_W-1:0];
        REG_RX_EN:       cfg_q.receive_enable       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ERROR_LIMIT: prdata = APB_DW'(cfg_q.error_limit);
      REG_SAVE_E:      prdata = APB_DW'(cfg_q.save_e_blocks);
      REG_UNSYNC_BLK:  prdata = APB_DW'(cfg_q.unsync_block_count);
      REG_UNSYNC_BIT:  prdata = APB_DW'(cfg_q.unsync_bit_count);
      REG_UNCORR_WGT:  prdata = APB_DW'(cfg_q.uncorrectable_weight);
      REG_FULL_THR:    prdata = APB_DW'(cfg_q.full_threshold);
      REG_RX_EN:       prdata = APB_DW'(cfg_q.receive_enable);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/rdsbsb_sync.sv */
// rds sync state machine with error grading and error accounting
// depends on rdsbsb_pkg and the core defines header
`include "rds_block_sync_and_buffer_core_defines.svh"
module rdsbsb_sync import rdsbsb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              go_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [ERR_W-1:0]  err_i,
  output sync_dec_t         dec_o,
  output logic [SYNC_W-1:0] state_o
);

  typedef enum logic [SYNC_W-1:0] {
    S_INIT = SYNC_INIT,
    S_HAVE = SYNC_HAVE,
    S_FULL = SYNC_FULL
  } sync_state_e;

  sync_state_e          sync_q, sync_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_BLK_W-1:0] cnt_q, cnt_d;
  logic [CLASS_W-1:0]   cls;
  logic [ERR_W-1:0]     weight;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_acc;
  logic [CNT_BLK_W-1:0] cnt_acc;

  always_comb begin
    if (err_i == '0) begin
      cls = CLASS_NONE;
    end else if (err_i <= GRADE_TWO_MAX && err_i <= cfg_i.error_limit) begin
      cls = CLASS_TWO;
    end else if (err_i <= GRADE_FIVE_MAX && err_i <= cfg_i.error_limit) begin
      cls = CLASS_FIVE;
    end else begin
      cls = CLASS_UNCORR;
    end
  end

  assign weight  = (cls == CLASS_UNCORR) ? cfg_i.uncorrectable_weight : err_i;
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(weight);

  always_comb begin
    sync_d  = sync_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    sum_acc = '0;
    cnt_acc = '0;
    dec_o   = '0;
    if (cfg_i.receive_enable) begin
      unique case (sync_q)
        S_INIT: sync_d = S_HAVE;
        S_HAVE: begin
          if (kind_i == KIND_A && err_i == '0) begin
            sync_d    = S_FULL;
            dec_o.store = 1'b1;
            dec_o.cls   = CLASS_NONE;
          end
        end
        S_FULL: begin
          dec_o.store = (kind_i != KIND_E) || cfg_i.save_e_blocks;
          dec_o.cls   = cls;
          if (weight != '0) begin
            sum_acc = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            cnt_acc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
          end
          sum_d = sum_acc;
          cnt_d = cnt_acc;
          if (cnt_acc >= cfg_i.unsync_block_count) begin
            if (sum_acc >= cfg_i.unsync_bit_count) begin
              sync_d = S_HAVE;
            end
            sum_d = '0;
            cnt_d = '0;
          end
        end
        default: ;
      endcase
    end
    dec_o.state_next = sync_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= S_INIT;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else if (go_i) begin
      sync_q <= sync_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
    end
  end

  assign state_o = sync_q;

  `RDSBSB_ASSERT_NOW(a_counters_clear, sync_q != S_FULL, sum_q == '0 && cnt_q == '0, "error counters set outside full sync")
  `RDSBSB_ASSERT_NEXT(a_no_reinit, sync_q != S_INIT, sync_q != S_INIT, "sync machine fell back to init")
  `RDSBSB_ASSERT_NEXT(a_hold_idle, !go_i, $stable(sync_q) && $stable(sum_q), "sync state moved without a word")

endmodule

/* rtl/core/rds_block_sync_and_buffer_core.sv */
// Flow: an incoming word is captured, then graded, with the sync machine and error counters
// updated and the ring ram written. A host read captures and sizes the transfer and issues the
// first ring ram read, then returns one block per cycle while the output is not stalled, a pace
// set by the registered read port; an empty read returns one result without blocks. Output
// stalls hold the walk. Results leave through an output register, and a new item is taken as
// soon as the previous one has finished its work even while its last result waits. The ring
// needs no clearing pass after reset.
//
// top level: config registers, sync machine, ring ram and read sequencer
// depends on rdsbsb_pkg, rdsbsb_regs, rdsbsb_sync, rdsbsb_ram and the core defines header
`include "rds_block_sync_and_buffer_core_defines.svh"
module rds_block_sync_and_buffer_core import rdsbsb_pkg::*; #(
  parameter int RING_BLOCKS  = RING_BLOCKS_DEF,
  parameter int GUARD_BLOCKS = GUARD_BLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  in_item_t          in_item_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output out_item_t         out_item_o,
  input  logic              out_stall_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W  = $clog2(RING_BLOCKS);
  localparam int FILL_W = $clog2(RING_BLOCKS + 1);
  localparam int CNT_W  = (FILL_W > REQ_W) ? FILL_W : REQ_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } ctrl_state_e;

  ctrl_state_e       state_q, state_d;
  in_item_t          item_q;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  logic              avail_q, avail_d, full_q, full_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              rdata_v_q, rdata_v_d, rlast_q, rlast_d;
  logic [CNT_W-1:0]  iss_left_q, iss_left_d, n_q, n_d;
  logic              drain_all_q, drain_all_d;

  cfg_t              cfg;
  sync_dec_t         dec;
  logic [SYNC_W-1:0] sync_state;
  logic              sync_go;

  logic [CNT_W-1:0]  fill, req_ext, thr_ext, n_calc;
  logic              can_store, out_free, move, issue, in_acc;
  logic              ram_we;
  entry_t            wentry, rentry;
  logic [ENTRY_W-1:0] ram_rdata;

  rdsbsb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rdsbsb_sync u_sync (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .go_i    (sync_go),
    .kind_i  (item_q.block_kind),
    .err_i   (item_q.error_count),
    .dec_o   (dec),
    .state_o (sync_state)
  );

  rdsbsb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_BLOCKS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (wentry),
    .re_i    (issue),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign fill = (rp_q > wp_q)
              ? (CNT_W'(RING_BLOCKS) - CNT_W'(rp_q) + CNT_W'(wp_q))
              : (CNT_W'(wp_q) - CNT_W'(rp_q));
  assign can_store = (CNT_W'(RING_BLOCKS) - fill) >= CNT_W'(GUARD_BLOCKS);
  assign req_ext   = CNT_W'(item_q.request_blocks);
  assign thr_ext   = CNT_W'(cfg.full_threshold);
  assign n_calc    = (req_ext < fill) ? req_ext : fill;

  assign wp_inc = (wp_q == PTR_W'(RING_BLOCKS - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == PTR_W'(RING_BLOCKS - 1)) ? '0 : rp_q + 1'b1;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign sync_go  = (state_q == ST_EXEC) && (item_q.action == ACT_WORD) && out_free;
  assign ram_we   = sync_go && dec.store && can_store;
  assign move     = (state_q == ST_DRAIN) && rdata_v_q && out_free;
  assign issue    = (state_q == ST_DRAIN) && (iss_left_q != '0) && (!rdata_v_q || move);

  assign rentry       = entry_t'(ram_rdata);
  assign wentry.avail = 1'b1;
  assign wentry.cls   = dec.cls;
  assign wentry.kind  = item_q.block_kind;
  assign wentry.data  = item_q.word_data;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    avail_d     = avail_q;
    full_d      = full_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rdata_v_d   = rdata_v_q;
    rlast_d     = rlast_q;
    iss_left_d  = iss_left_q;
    n_d         = n_q;
    drain_all_d = drain_all_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_q.action == ACT_WORD) begin
          if (out_free) begin
            out_d = '0;
            if (ram_we) begin
              wp_d = wp_inc;
              if (fill != '0) begin
                avail_d = 1'b1;
              end
            end
            if (dec.store && thr_ext != '0 && fill >= thr_ext) begin
              full_d = 1'b1;
              out_d.new_data_event = 1'b1;
            end
            out_d.word_stored    = ram_we;
            out_d.last           = 1'b1;
            out_d.sync_status    = dec.state_next;
            out_d.data_available = avail_d;
            out_d.buffer_full    = full_d;
            out_valid_d          = 1'b1;
            state_d              = ST_IDLE;
          end
        end else if (n_calc == '0) begin
          if (out_free) begin
            out_d                = '0;
            out_d.last           = 1'b1;
            out_d.sync_status    = sync_state;
            out_d.data_available = avail_q;
            out_d.buffer_full    = full_q;
            out_valid_d          = 1'b1;
            state_d              = ST_IDLE;
          end
        end else begin
          if (n_calc == fill) begin
            avail_d = 1'b0;
          end
          if (n_calc < thr_ext) begin
            full_d = 1'b0;
          end
          iss_left_d  = n_calc;
          n_d         = n_calc;
          drain_all_d = (n_calc == fill);
          state_d     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (issue) begin
          rp_d       = rp_inc;
          iss_left_d = iss_left_q - 1'b1;
          rlast_d    = (iss_left_q == CNT_W'(1));
          rdata_v_d  = 1'b1;
        end else if (move) begin
          rdata_v_d = 1'b0;
        end
        if (move) begin
          out_d.block_valid    = 1'b1;
          out_d.out_data       = rentry.data;
          out_d.out_block_kind = rentry.kind;
          out_d.error_class    = rentry.cls;
          out_d.avail_mark     = rentry.avail && !(rlast_q && drain_all_q);
          out_d.last           = rlast_q;
          out_d.blocks_read    = n_q[REQ_W-1:0];
          out_d.sync_status    = sync_state;
          out_d.data_available = avail_q;
          out_d.buffer_full    = full_q;
          out_d.new_data_event = 1'b0;
          out_d.word_stored    = 1'b0;
          out_valid_d          = 1'b1;
          if (rlast_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      avail_q     <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      rdata_v_q   <= 1'b0;
      rlast_q     <= 1'b0;
      iss_left_q  <= '0;
      n_q         <= '0;
      drain_all_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      avail_q     <= avail_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      rdata_v_q   <= rdata_v_d;
      rlast_q     <= rlast_d;
      iss_left_q  <= iss_left_d;
      n_q         <= n_d;
      drain_all_q <= drain_all_d;
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RDSBSB_ASSERT_NOW(a_issue_slot, issue, !rdata_v_q || move, "ring read issued over a held block")
  `RDSBSB_ASSERT_NOW(a_idle_clean, state_q == ST_IDLE, !rdata_v_q && iss_left_q == '0, "read walk left work behind")
  `RDSBSB_ASSERT_NEXT(a_drain_end, move && rlast_q, state_q == ST_IDLE && out_valid_q && out_q.last, "final block did not end the read")

endmodule
